@@ sv/uhg_pkg.sv @@
package uhg_pkg;

   localparam int HDR_WORDS   = 21;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
   localparam logic [15:0] IP_IDENT       = 16'h0001;
   localparam logic [15:0] IP_FRAG        = 16'h0000;
   localparam logic [15:0] IP_TTL_PROTO   = 16'h4011;
   localparam logic [15:0] UDP_CHECKSUM   = 16'h0000;
   localparam logic [15:0] IP_HDR_EXTRA   = 16'd28;
   localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

   // Constant part of the IPv4 checksum sum: version/IHL/TOS, identification,
   // fragment word, TTL/protocol, and the header bytes inside the total length.
   localparam logic [15:0] CSUM_BASE = 16'h852E;

   localparam int CSR_MAC_W  = 48;
   localparam int CSR_IP_W   = 32;
   localparam int CSR_PORT_W = 16;

   typedef logic [10:0] length_type;
   typedef logic [4:0]  index_type;
   typedef logic [2:0]  csr_index_type;

   typedef enum logic [2:0] {
      CSR_SOURCE_MAC  = 3'd0,
      CSR_DEST_MAC    = 3'd1,
      CSR_SOURCE_IP   = 3'd2,
      CSR_DEST_IP     = 3'd3,
      CSR_SOURCE_PORT = 3'd4,
      CSR_DEST_PORT   = 3'd5
   } csr_reg_type;

   typedef enum logic [4:0] {
      W_DMAC_HI   = 5'd0,
      W_DMAC_MID  = 5'd1,
      W_DMAC_LO   = 5'd2,
      W_SMAC_HI   = 5'd3,
      W_SMAC_MID  = 5'd4,
      W_SMAC_LO   = 5'd5,
      W_ETHERTYPE = 5'd6,
      W_VER_TOS   = 5'd7,
      W_TOTAL_LEN = 5'd8,
      W_IDENT     = 5'd9,
      W_FRAG      = 5'd10,
      W_TTL_PROTO = 5'd11,
      W_CHECKSUM  = 5'd12,
      W_SIP_HI    = 5'd13,
      W_SIP_LO    = 5'd14,
      W_DIP_HI    = 5'd15,
      W_DIP_LO    = 5'd16,
      W_SPORT     = 5'd17,
      W_DPORT     = 5'd18,
      W_UDP_LEN   = 5'd19,
      W_UDP_CSUM  = 5'd20
   } word_pos_type;

   localparam index_type LAST_INDEX = index_type'(HDR_WORDS - 1);

   typedef struct packed {
      logic [CSR_MAC_W-1:0]  source_mac;
      logic [CSR_MAC_W-1:0]  dest_mac;
      logic [CSR_IP_W-1:0]   source_ip;
      logic [CSR_IP_W-1:0]   dest_ip;
      logic [CSR_PORT_W-1:0] source_port;
      logic [CSR_PORT_W-1:0] dest_port;
   } cfg_type;

   typedef struct packed {
      length_type  length;
      logic        error;
      logic [15:0] checksum;
   } item_type;

endpackage

@@ sv/uhg_front.sv @@
module uhg_front import uhg_pkg::*; #(
   parameter int MAX_PAYLOAD = 1472
) (
   input  logic       req_valid,
   input  length_type req_payload_length,
   input  logic       queue_full,
   input  cfg_type    cfg,
   output logic       req_stall,
   output logic       push,
   output item_type   push_item
);

   logic [18:0] sum;
   logic [16:0] fold1;
   logic [16:0] fold2;

   always_comb begin
      sum = 19'(CSUM_BASE) + 19'(req_payload_length)
          + 19'(cfg.source_ip[31:16]) + 19'(cfg.source_ip[15:0])
          + 19'(cfg.dest_ip[31:16]) + 19'(cfg.dest_ip[15:0]);
      fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
      fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
   end

   assign req_stall          = queue_full;
   assign push               = req_valid && !queue_full;
   assign push_item.length   = req_payload_length;
   assign push_item.error    = (req_payload_length > length_type'(MAX_PAYLOAD));
   assign push_item.checksum = ~fold2[15:0];

endmodule

@@ sv/uhg_queue.sv @@
module uhg_queue import uhg_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output item_type head
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      if (p == PtrW'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PtrW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == CntW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

endmodule

@@ sv/uhg_back.sv @@
module uhg_back import uhg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        queue_not_empty,
   input  item_type    queue_head,
   output logic        pop,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [15:0] rsp_header_word,
   output index_type   rsp_word_index,
   output logic        rsp_last_word,
   output logic        rsp_length_error
);

   logic        active_ff, active_in;
   index_type   idx_ff, idx_in;
   item_type    item_ff, item_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] word_ff, word_in;
   index_type   index_ff, index_in;
   logic        last_ff, last_in;
   logic        err_ff, err_in;

   logic        load;
   logic        emit;
   logic        emit_last;
   logic [15:0] word_sel;

   always_comb begin
      case (word_pos_type'(idx_ff))
         W_DMAC_HI:   word_sel = cfg.dest_mac[47:32];
         W_DMAC_MID:  word_sel = cfg.dest_mac[31:16];
         W_DMAC_LO:   word_sel = cfg.dest_mac[15:0];
         W_SMAC_HI:   word_sel = cfg.source_mac[47:32];
         W_SMAC_MID:  word_sel = cfg.source_mac[31:16];
         W_SMAC_LO:   word_sel = cfg.source_mac[15:0];
         W_ETHERTYPE: word_sel = ETHERTYPE_IPV4;
         W_VER_TOS:   word_sel = IP_VER_IHL_TOS;
         W_TOTAL_LEN: word_sel = IP_HDR_EXTRA + 16'(item_ff.length);
         W_IDENT:     word_sel = IP_IDENT;
         W_FRAG:      word_sel = IP_FRAG;
         W_TTL_PROTO: word_sel = IP_TTL_PROTO;
         W_CHECKSUM:  word_sel = item_ff.checksum;
         W_SIP_HI:    word_sel = cfg.source_ip[31:16];
         W_SIP_LO:    word_sel = cfg.source_ip[15:0];
         W_DIP_HI:    word_sel = cfg.dest_ip[31:16];
         W_DIP_LO:    word_sel = cfg.dest_ip[15:0];
         W_SPORT:     word_sel = cfg.source_port;
         W_DPORT:     word_sel = cfg.dest_port;
         W_UDP_LEN:   word_sel = UDP_HDR_BYTES + 16'(item_ff.length);
         W_UDP_CSUM:  word_sel = UDP_CHECKSUM;
         default:     word_sel = '0;
      endcase
   end

   always_comb begin
      load      = !rsp_valid_ff || !rsp_stall;
      emit      = active_ff && load;
      emit_last = emit && (idx_ff == LAST_INDEX);
      // The next item is taken in the same cycle the last word of the
      // current one goes out, so runs follow each other without a gap.
      pop       = queue_not_empty && (!active_ff || emit_last);

      active_in = active_ff;
      idx_in    = idx_ff;
      item_in   = item_ff;
      if (pop) begin
         active_in = 1'b1;
         idx_in    = '0;
         item_in   = queue_head;
      end else if (emit_last) begin
         active_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + index_type'(1);
      end

      rsp_valid_in = rsp_valid_ff;
      word_in      = word_ff;
      index_in     = index_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      if (load) begin
         rsp_valid_in = emit;
         word_in      = word_sel;
         index_in     = idx_ff;
         last_in      = (idx_ff == LAST_INDEX);
         err_in       = item_ff.error;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      word_ff  <= word_in;
      index_ff <= index_in;
      last_ff  <= last_in;
      err_ff   <= err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_header_word  = word_ff;
   assign rsp_word_index   = index_ff;
   assign rsp_last_word    = last_ff;
   assign rsp_length_error = err_ff;

endmodule

@@ sv/udp_ipv4_header_generator.sv @@
// Each request produces 21 header words, one per cycle while rsp_stall is low.
// A request passes the queue, the item register and the output register.
// Headers go out one after another through the single 16-bit output word.
// A two-entry request queue lets new requests be taken while a header streams out.
// Synchronous active-high reset empties the queue and output and reloads the
// address and port registers with their default values.
module udp_ipv4_header_generator import uhg_pkg::*; #(
   parameter int MAX_PAYLOAD = 1472
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [10:0]           req_payload_length,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [15:0]           rsp_header_word,
   output logic [4:0]            rsp_word_index,
   output logic                  rsp_last_word,
   output logic                  rsp_length_error,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [2:0]            csr_index,
   input  logic [CSR_MAC_W-1:0]  csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     push;
   item_type push_item;
   logic     pop;
   logic     queue_full;
   logic     queue_not_empty;
   item_type queue_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SOURCE_MAC:  cfg_in.source_mac  = csr_data;
            CSR_DEST_MAC:    cfg_in.dest_mac    = csr_data;
            CSR_SOURCE_IP:   cfg_in.source_ip   = csr_data[CSR_IP_W-1:0];
            CSR_DEST_IP:     cfg_in.dest_ip     = csr_data[CSR_IP_W-1:0];
            CSR_SOURCE_PORT: cfg_in.source_port = csr_data[CSR_PORT_W-1:0];
            CSR_DEST_PORT:   cfg_in.dest_port   = csr_data[CSR_PORT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_mac  <= 48'h001A2B3C4D5E;
         cfg_ff.dest_mac    <= 48'h001A2B3C4D5F;
         cfg_ff.source_ip   <= 32'hC0A80101;
         cfg_ff.dest_ip     <= 32'hC0A80102;
         cfg_ff.source_port <= 16'd8888;
         cfg_ff.dest_port   <= 16'd8889;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   uhg_front #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_front (
      .req_valid          (req_valid),
      .req_payload_length (req_payload_length),
      .queue_full         (queue_full),
      .cfg                (cfg_ff),
      .req_stall          (req_stall),
      .push               (push),
      .push_item          (push_item)
   );

   uhg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   uhg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .queue_not_empty  (queue_not_empty),
      .queue_head       (queue_head),
      .pop              (pop),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_header_word  (rsp_header_word),
      .rsp_word_index   (rsp_word_index),
      .rsp_last_word    (rsp_last_word),
      .rsp_length_error (rsp_length_error)
   );

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top import uhg_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAYLOAD = 1472;
   localparam int LONG_HOLD   = 400;
   localparam int SETTLE      = 8;

   // Indexes past the last register; writes to them must change nothing.
   localparam csr_index_type CSR_SPARE_LO = 3'd6;
   localparam csr_index_type CSR_SPARE_HI = 3'd7;

   localparam cfg_type ADDR_DEFAULTS = '{
      source_mac:  48'h001A2B3C4D5E,
      dest_mac:    48'h001A2B3C4D5F,
      source_ip:   32'hC0A80101,
      dest_ip:     32'hC0A80102,
      source_port: 16'd8888,
      dest_port:   16'd8889
   };

   typedef struct packed {
      logic [15:0] word;
      index_type   index;
      logic        last;
      logic        error;
   } hdr_word_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   length_type           req_payload_length;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [15:0]          rsp_header_word;
   index_type            rsp_word_index;
   logic                 rsp_last_word;
   logic                 rsp_length_error;
   logic                 csr_valid;
   logic                 csr_ready;
   csr_index_type        csr_index;
   logic [CSR_MAC_W-1:0] csr_data;

   cfg_type      addr_cfg;
   length_type   lengths_to_send[$];
   hdr_word_type words_due[$];
   int           mismatches;
   int           send_idle_pct;
   int           recv_idle_pct;
   int           holds_asked;
   int           holds_served;
   int           hold_left;

   udp_ipv4_header_generator #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_payload_length (req_payload_length),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_header_word    (rsp_header_word),
      .rsp_word_index     (rsp_word_index),
      .rsp_last_word      (rsp_last_word),
      .rsp_length_error   (rsp_length_error),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #10 clock = ~clock;

   // Queues the 21 header words that one payload length must produce.
   function automatic void build_header(length_type len);
      logic [15:0]  w [HDR_WORDS];
      logic [31:0]  sum;
      logic         oversize;
      hdr_word_type entry;
      oversize = int'(len) > MAX_PAYLOAD;
      w[W_DMAC_HI]   = addr_cfg.dest_mac[47:32];
      w[W_DMAC_MID]  = addr_cfg.dest_mac[31:16];
      w[W_DMAC_LO]   = addr_cfg.dest_mac[15:0];
      w[W_SMAC_HI]   = addr_cfg.source_mac[47:32];
      w[W_SMAC_MID]  = addr_cfg.source_mac[31:16];
      w[W_SMAC_LO]   = addr_cfg.source_mac[15:0];
      w[W_ETHERTYPE] = ETHERTYPE_IPV4;
      w[W_VER_TOS]   = IP_VER_IHL_TOS;
      w[W_TOTAL_LEN] = 16'(len) + IP_HDR_EXTRA;
      w[W_IDENT]     = IP_IDENT;
      w[W_FRAG]      = IP_FRAG;
      w[W_TTL_PROTO] = IP_TTL_PROTO;
      w[W_CHECKSUM]  = 16'h0000;
      w[W_SIP_HI]    = addr_cfg.source_ip[31:16];
      w[W_SIP_LO]    = addr_cfg.source_ip[15:0];
      w[W_DIP_HI]    = addr_cfg.dest_ip[31:16];
      w[W_DIP_LO]    = addr_cfg.dest_ip[15:0];
      w[W_SPORT]     = addr_cfg.source_port;
      w[W_DPORT]     = addr_cfg.dest_port;
      w[W_UDP_LEN]   = 16'(len) + UDP_HDR_BYTES;
      w[W_UDP_CSUM]  = UDP_CHECKSUM;
      sum = 32'd0;
      for (int i = W_VER_TOS; i <= W_DIP_LO; i++) begin
         sum += 32'(w[i]);
      end
      // Two folds are enough: the first leaves at most a single carry.
      sum = {16'h0000, sum[31:16]} + {16'h0000, sum[15:0]};
      sum = {16'h0000, sum[31:16]} + {16'h0000, sum[15:0]};
      w[W_CHECKSUM] = ~sum[15:0];
      for (int i = 0; i < HDR_WORDS; i++) begin
         entry.word  = w[i];
         entry.index = index_type'(i);
         entry.last  = (index_type'(i) == LAST_INDEX);
         entry.error = oversize;
         words_due.push_back(entry);
      end
   endfunction

   function automatic void compare_field(string what, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Driver: offers the front of the queue and holds it steady while stalled.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            build_header(req_payload_length);
            void'(lengths_to_send.pop_front());
         end
         if (lengths_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid          <= 1'b1;
            req_payload_length <= lengths_to_send[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each accepted word and drives the receiver's stall.
   always @(posedge clock) begin
      hdr_word_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (words_due.size() == 0) begin
               $display("%0t ns: word expected none, got %h index %0d",
                        $time, rsp_header_word, rsp_word_index);
               mismatches++;
            end else begin
               due = words_due.pop_front();
               compare_field("header_word", rsp_header_word, due.word);
               compare_field("word_index", 16'(rsp_word_index), 16'(due.index));
               compare_field("last_word", 16'(rsp_last_word), 16'(due.last));
               compare_field("length_error", 16'(rsp_length_error), 16'(due.error));
            end
         end
         if (holds_served != holds_asked) begin
            hold_left = LONG_HOLD;
            holds_served++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [CSR_MAC_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SOURCE_MAC:  addr_cfg.source_mac  = value;
         CSR_DEST_MAC:    addr_cfg.dest_mac    = value;
         CSR_SOURCE_IP:   addr_cfg.source_ip   = value[CSR_IP_W-1:0];
         CSR_DEST_IP:     addr_cfg.dest_ip     = value[CSR_IP_W-1:0];
         CSR_SOURCE_PORT: addr_cfg.source_port = value[CSR_PORT_W-1:0];
         CSR_DEST_PORT:   addr_cfg.dest_port   = value[CSR_PORT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(logic [CSR_MAC_W-1:0] value);
      write_csr(CSR_SOURCE_MAC, value);
      write_csr(CSR_DEST_MAC, value);
      write_csr(CSR_SOURCE_IP, value);
      write_csr(CSR_DEST_IP, value);
      write_csr(CSR_SOURCE_PORT, value);
      write_csr(CSR_DEST_PORT, value);
   endtask

   function automatic logic [CSR_MAC_W-1:0] random_wide();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[CSR_MAC_W-1:0];
   endfunction

   // Full 48-bit data goes to every register so the narrow ones must drop bits.
   task automatic scramble_addresses();
      write_csr(CSR_SOURCE_MAC, random_wide());
      write_csr(CSR_DEST_MAC, random_wide());
      write_csr(CSR_SOURCE_IP, random_wide());
      write_csr(CSR_DEST_IP, random_wide());
      write_csr(CSR_SOURCE_PORT, random_wide());
      write_csr(CSR_DEST_PORT, random_wide());
      if ($urandom_range(1)) begin
         write_csr($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, random_wide());
      end
   endtask

   function automatic length_type pick_length();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         return length_type'($urandom_range(MAX_PAYLOAD));
      end else if (roll < 90) begin
         return length_type'($urandom_range(2047, MAX_PAYLOAD + 1));
      end
      case ($urandom_range(3))
         0:       return length_type'(0);
         1:       return length_type'(MAX_PAYLOAD);
         2:       return length_type'(MAX_PAYLOAD + 1);
         default: return length_type'(2047);
      endcase
   endfunction

   // The sender pauses here until every queued header has come out.
   task automatic wait_until_idle();
      while (lengths_to_send.size() != 0 || words_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send_random(int count);
      for (int i = 0; i < count; i++) begin
         lengths_to_send.push_back(pick_length());
      end
      wait_until_idle();
   endtask

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_payload_length = '0;
      rsp_stall          = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      addr_cfg           = ADDR_DEFAULTS;
      mismatches         = 0;
      holds_asked        = 0;
      holds_served       = 0;
      send_idle_pct      = 13;
      recv_idle_pct      = 52;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed lengths against the reset addresses: extremes, the size limit, bit patterns.
      lengths_to_send.push_back(length_type'(0));
      lengths_to_send.push_back(length_type'(1));
      lengths_to_send.push_back(length_type'(2));
      lengths_to_send.push_back(length_type'(MAX_PAYLOAD - 1));
      lengths_to_send.push_back(length_type'(MAX_PAYLOAD));
      lengths_to_send.push_back(length_type'(MAX_PAYLOAD + 1));
      lengths_to_send.push_back(length_type'(11'h555));
      lengths_to_send.push_back(length_type'(11'h2AA));
      lengths_to_send.push_back(length_type'(2046));
      lengths_to_send.push_back(length_type'(2047));
      wait_until_idle();

      // All-ones addresses push the checksum sum through several carries.
      write_all('1);
      write_csr(CSR_SPARE_LO, '0);
      write_csr(CSR_SPARE_HI, '0);
      lengths_to_send.push_back(length_type'(0));
      lengths_to_send.push_back(length_type'(1000));
      lengths_to_send.push_back(length_type'(MAX_PAYLOAD));
      lengths_to_send.push_back(length_type'(MAX_PAYLOAD + 1));
      lengths_to_send.push_back(length_type'(2047));
      wait_until_idle();

      write_all('0);
      lengths_to_send.push_back(length_type'(0));
      lengths_to_send.push_back(length_type'(5));
      lengths_to_send.push_back(length_type'(2047));
      wait_until_idle();

      scramble_addresses();
      send_random(42);
      scramble_addresses();
      send_random(42);

      send_idle_pct = 52;
      recv_idle_pct = 13;
      scramble_addresses();
      send_random(42);
      scramble_addresses();
      send_random(42);

      // No idling; a long receiver hold first backs the block up to its input.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      scramble_addresses();
      holds_asked++;
      send_random(42);
      scramble_addresses();
      send_random(42);

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
